[rtl/gaussian_pair_force_assert.svh]
// ----------------------------------------------------------------------------
// Gaussian pair force assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_PAIR_FORCE_ASSERT_SVH
`define GAUSSIAN_PAIR_FORCE_ASSERT_SVH

`ifndef SYNTH
`define GPF_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("gaussian_pair_force check failed");
`define GPF_ASSERT_NEXT(label, clk, a, c) \
  label: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("gaussian_pair_force check failed");
`else
`define GPF_ASSERT_IMPL(label, clk, rst, a, c)
`define GPF_ASSERT_NEXT(label, clk, a, c)
`endif

`endif

[rtl/gpf_pkg.sv]
// ----------------------------------------------------------------------------
// gpf_pkg
// Shared types and fixed-point constants of the gaussian pair force unit.
// ----------------------------------------------------------------------------
`default_nettype none
package gpf_pkg;

  localparam int Q30_BITS = 30;
  localparam int TQ_BITS  = 34;
  localparam int E_W      = 31;

  typedef enum logic [2:0] {
    REG_FORCE_PREFACTOR  = 3'd0,
    REG_EXPONENT_FACTOR  = 3'd1,
    REG_ENERGY_PREFACTOR = 3'd2,
    REG_CUTOFF_SQ        = 3'd3,
    REG_ENERGY_ENABLE    = 3'd4
  } cfg_reg_t;

  // per-pair side data carried down the pipeline
  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic             in_range;
  } pair_side_t;

endpackage
`default_nettype wire

[rtl/gpf_exp_interp.sv]
// ----------------------------------------------------------------------------
// gpf_exp_interp
// Four-stage exp(-t) unit: scale t, look up two ROM entries, interpolate.
// ----------------------------------------------------------------------------
`default_nettype none
module gpf_exp_interp #(
  parameter int EXP_TABLE_DEPTH = 256,
  parameter int FRAC_BITS       = 16
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [63:0]            p_lo,
  input  wire logic [63:0]            p_hi,
  output logic      [gpf_pkg::E_W-1:0] e
);

  localparam int IDX_W = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int POS_W = gpf_pkg::TQ_BITS + IDX_W;
  localparam int SH    = 3 * FRAC_BITS - gpf_pkg::Q30_BITS;
  localparam int BOUND = 3 * FRAC_BITS + 4;
  localparam logic [63:0] STEP = (64'd16 << 30) / EXP_TABLE_DEPTH;

  typedef logic [gpf_pkg::E_W-1:0] rom_t [EXP_TABLE_DEPTH+1];

  function automatic rom_t build_rom();
    rom_t   r;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] es;
    logic [63:0] prev;
    term = 64'd1 << 30;
    pos  = 64'd1 << 30;
    neg  = 64'd0;
    for (int n = 1; n <= 20; n++) begin
      term = ((term * STEP) >> 30) / 64'(n);
      if (n % 2 == 1) neg = neg + term;
      else            pos = pos + term;
    end
    es   = (pos > neg) ? pos - neg : 64'd0;
    prev = 64'd1 << 30;
    r[0] = gpf_pkg::E_W'(prev);
    for (int k = 1; k <= EXP_TABLE_DEPTH; k++) begin
      prev = (prev * es) >> 30;
      r[k] = gpf_pkg::E_W'(prev);
    end
    return r;
  endfunction

  localparam rom_t EXP_ROM = build_rom();

  // stage A: full product, range check, table position
  logic [95:0]                   prod_t;
  logic [gpf_pkg::TQ_BITS-1:0]   tq;
  logic [POS_W-1:0]              pos_c;
  logic [IDX_W-1:0]              idx;
  logic [gpf_pkg::Q30_BITS-1:0]  frac_a;
  logic                          past_a;

  assign prod_t = {32'd0, p_lo} + {p_hi, 32'd0};

  generate
    if (SH >= 0) begin : g_shr
      assign tq = gpf_pkg::TQ_BITS'(prod_t >> SH);
    end else begin : g_shl
      assign tq = gpf_pkg::TQ_BITS'(prod_t << (-SH));
    end
  endgenerate

  assign pos_c = {{IDX_W{1'b0}}, tq} * POS_W'(EXP_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (en) begin
      idx    <= pos_c[POS_W-1:gpf_pkg::TQ_BITS];
      frac_a <= pos_c[gpf_pkg::TQ_BITS-1:4];
      past_a <= ((prod_t >> BOUND) != 96'd0);
    end
  end

  // stage B: read both neighbours, form the step
  logic [gpf_pkg::E_W-1:0]      a_b;
  logic [gpf_pkg::E_W-1:0]      d_b;
  logic [gpf_pkg::Q30_BITS-1:0] frac_b;
  logic                         past_b;

  always_ff @(posedge clk) begin
    if (en) begin
      a_b    <= EXP_ROM[idx];
      d_b    <= EXP_ROM[idx] - EXP_ROM[IDX_W'(idx + IDX_W'(1))];
      frac_b <= frac_a;
      past_b <= past_a;
    end
  end

  // stage C: scale the step by the fraction
  logic [gpf_pkg::E_W-1:0]                   a_c;
  logic [gpf_pkg::E_W+gpf_pkg::Q30_BITS-1:0] m_c;
  logic                                      past_c;

  always_ff @(posedge clk) begin
    if (en) begin
      a_c    <= a_b;
      m_c    <= d_b * frac_b;
      past_c <= past_b;
    end
  end

  // stage D: interpolated value, zero past the table end
  always_ff @(posedge clk) begin
    if (en) begin
      e <= past_c ? '0 : a_c - gpf_pkg::E_W'(m_c >> gpf_pkg::Q30_BITS);
    end
  end

endmodule
`default_nettype wire

[rtl/gaussian_pair_force.sv]
// ----------------------------------------------------------------------------
// gaussian_pair_force
// Pair force and energy of a gaussian potential for one neighbour pair.
// ----------------------------------------------------------------------------
// Takes one pair separation per beat and returns the force on the first atom,
// the pair energy and a cutoff flag. Eleven register stages sit between the
// input and the output beat, and one pair is taken every cycle while the
// output side keeps up. The whole pipeline advances together whenever the
// output register is empty or being read, so s_tready follows m_tready with
// no extra delay and a stall holds every stage in place. Configuration writes
// are taken every cycle and must only happen while no pair is in flight.
// exp(-t) comes from an interpolated table of EXP_TABLE_DEPTH steps over t in
// [0,16); beyond it the force and energy are zero although within_cutoff
// stays set.
// ----------------------------------------------------------------------------
`default_nettype none
module gaussian_pair_force #(
  parameter int EXP_TABLE_DEPTH = 256,
  parameter int FRAC_BITS       = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // input pair beat
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [95:0]  s_tdata,  // diff_x[31:0], diff_y[63:32], diff_z[95:64]
  // result beat
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [127:0]      m_tdata,  // force_x, force_y, force_z, pair_energy
  output logic              m_tuser,  // within_cutoff
  // register writes
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);

  localparam int NSTG = 10;

  // configuration registers
  logic [31:0] force_prefactor;
  logic [31:0] exponent_factor;
  logic [31:0] energy_prefactor;
  logic [63:0] cutoff_sq;
  logic        energy_enable;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      force_prefactor  <= '0;
      exponent_factor  <= '0;
      energy_prefactor <= '0;
      cutoff_sq        <= '0;
      energy_enable    <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gpf_pkg::REG_FORCE_PREFACTOR:  force_prefactor  <= cfg_data[31:0];
        gpf_pkg::REG_EXPONENT_FACTOR:  exponent_factor  <= cfg_data[31:0];
        gpf_pkg::REG_ENERGY_PREFACTOR: energy_prefactor <= cfg_data[31:0];
        gpf_pkg::REG_CUTOFF_SQ:        cutoff_sq        <= cfg_data;
        gpf_pkg::REG_ENERGY_ENABLE:    energy_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // advance every stage together when the output slot frees up
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  logic                vld  [1:NSTG];
  gpf_pkg::pair_side_t side [1:NSTG];

  // stage 1: take magnitudes and signs
  gpf_pkg::pair_side_t in_side;
  always_comb begin
    in_side = '0;
    for (int i = 0; i < 3; i++) begin
      in_side.neg[i] = s_tdata[32*i+31];
      in_side.mag[i] = s_tdata[32*i+31] ? 32'(-s_tdata[32*i +: 32]) : s_tdata[32*i +: 32];
    end
  end

  // stage 2 squares, stage 3 sum and cutoff compare
  logic [2:0][63:0] sq;
  logic [63:0]      r2;
  logic [63:0]      r2_sum;
  logic             r2_in;

  assign r2_sum = sq[0] + sq[1] + sq[2];
  assign r2_in  = (r2_sum < cutoff_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NSTG; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[1] <= s_tvalid;
      for (int k = 2; k <= NSTG; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[1] <= in_side;
      side[2] <= side[1];
      side[3] <= '{mag: side[2].mag, neg: side[2].neg, in_range: r2_in};
      for (int k = 4; k <= NSTG; k++) side[k] <= side[k-1];
      for (int i = 0; i < 3; i++) sq[i] <= side[1].mag[i] * side[1].mag[i];
      r2 <= r2_sum;
    end
  end

  // stage 4: t = exponent_factor * r2 as two partial products
  logic [63:0] p_lo;
  logic [63:0] p_hi;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_lo <= exponent_factor * r2[31:0];
      p_hi <= exponent_factor * r2[63:32];
    end
  end

  // stages 5 to 8: exp(-t) lookup and interpolation
  logic [gpf_pkg::E_W-1:0] e;

  gpf_exp_interp #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
    .FRAC_BITS       (FRAC_BITS)
  ) u_exp (
    .clk  (clk),
    .en   (adv),
    .p_lo (p_lo),
    .p_hi (p_hi),
    .e    (e)
  );

  // stage 9: pair scalar and energy
  logic [31:0] fq;
  logic [31:0] energy9;
  logic [62:0] fq_full;
  logic [62:0] en_full;

  assign fq_full = force_prefactor * e;
  assign en_full = energy_prefactor * e;

  always_ff @(posedge clk) begin
    if (adv) begin
      fq      <= 32'(fq_full >> gpf_pkg::Q30_BITS);
      energy9 <= energy_enable ? 32'(en_full >> gpf_pkg::Q30_BITS) : 32'd0;
    end
  end

  // stage 10: force magnitudes
  logic [2:0][63:0] fm;
  logic [31:0]      energy10;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) fm[i] <= side[9].mag[i] * fq;
      energy10 <= energy9;
    end
  end

  // stage 11: truncate, saturate, apply sign, drop pairs outside the cutoff
  function automatic logic [31:0] sat_force(input logic [63:0] f, input logic neg);
    logic [63:0] s;
    s = f >> FRAC_BITS;
    if (!neg) return (s > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : s[31:0];
    if (s >= 64'h8000_0000) return 32'h8000_0000;
    return 32'(-s[31:0]);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= vld[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        m_tdata[32*i +: 32] <= side[NSTG].in_range ?
                               sat_force(fm[i], side[NSTG].neg[i]) : 32'd0;
      end
      m_tdata[127:96] <= side[NSTG].in_range ? energy10 : 32'd0;
      m_tuser         <= side[NSTG].in_range;
    end
  end

  // checks
  `include "gaussian_pair_force_assert.svh"

  `GPF_ASSERT_IMPL(a_outside_zero, clk, rst, m_tvalid && !m_tuser, m_tdata == 128'd0)
  `GPF_ASSERT_NEXT(a_reset_empty, clk, rst, !m_tvalid)

endmodule
`default_nettype wire
